// ===== rtl/cp1251_to_utf8_encoder_core_assert.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef CP1251_TO_UTF8_ENCODER_CORE_ASSERT_SVH
`define CP1251_TO_UTF8_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2U_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define C2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

// ===== rtl/c2u_pkg.sv =====
package c2u_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 17;
    localparam int CODE_W  = 24;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CODE_W-1:0]  code_t;

    localparam len_t  BUFFER_LENGTH_RESET = 16'hFFFF;
    localparam byte_t ASCII_LIMIT         = 8'h80;
    localparam byte_t TERMINATOR          = 8'h00;

    // UTF-8 forms of 0x80..0xFF, first byte in bits 7..0; zero marks an unmapped code.
    localparam code_t HI_HALF_UTF8 [128] = '{
        24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
        24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
        24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
        24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
        24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
        24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
        24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
        24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
        24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
        24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
        24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
        24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
        24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
        24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
        24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
        24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
        24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
        24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
        24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
        24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
        24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
        24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
        24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
        24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
        24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
        24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
        24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
        24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
        24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
        24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
        24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
        24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
    };

    function automatic code_t hi_half_lookup(input logic [6:0] idx);
        return HI_HALF_UTF8[idx];
    endfunction

endpackage

// ===== rtl/c2u_if.sv =====
interface c2u_in_if;
    import c2u_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface c2u_out_if;
    import c2u_pkg::*;

    logic   valid;
    logic   ready;
    byte_t  out_byte;
    logic   last_of_run;
    logic   end_of_string;
    count_t written_length;

    modport source (
        output valid, output out_byte, output last_of_run,
        output end_of_string, output written_length, input ready
    );
    modport sink (
        input valid, input out_byte, input last_of_run,
        input end_of_string, input written_length, output ready
    );
endinterface

// ===== rtl/cp1251_to_utf8_encoder_core.sv =====
// Channel      Dir   Beat payload
// in_stream    in    in_byte: one Windows-1251 byte, zero ends the string
// out_stream   out   out_byte, last_of_run, end_of_string, written_length
// cfg_wr_*     in    buffer_length write, no handshake
//
// An input beat is decoded in the cycle it is accepted into the item register.
// The item register feeds the output register one byte per cycle unless the output
// stalls; an item has one, two or three bytes, and beats with no result give none.
// A new beat is accepted in the cycle the item register hands over its last byte.
// Output stalls back up through the item register to in_stream.ready.
// Reset clears the count, the valid flags and sets buffer_length to 65535.
module cp1251_to_utf8_encoder_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [c2u_pkg::LEN_W-1:0] cfg_wr_data,
    c2u_in_if.sink                  in_stream,
    c2u_out_if.source               out_stream
);
    import c2u_pkg::*;

    `include "cp1251_to_utf8_encoder_core_assert.svh"

    len_t   buffer_length_reg;
    count_t count_reg;
    count_t count_next;

    logic   item_valid_reg;
    logic   item_valid_next;
    code_t  item_bytes_reg;
    logic [1:0] item_n_reg;
    logic [1:0] item_idx_reg;
    logic [1:0] item_idx_next;
    logic   item_eos_reg;
    count_t item_base_reg;

    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_last_reg;
    logic   out_eos_reg;
    count_t out_len_reg;

    logic   out_load;
    logic   item_last;
    logic   item_done;
    logic   in_fire;
    logic   is_eos;
    logic   is_full;
    code_t  hi_code;
    code_t  dec_bytes;
    logic [1:0] dec_n;
    logic   produce;
    byte_t  sel_byte;

    assign out_load  = !out_valid_reg || out_stream.ready;
    assign item_last = (item_idx_reg == item_n_reg - 2'd1);
    assign item_done = item_valid_reg && out_load && item_last;

    assign in_stream.ready = !item_valid_reg || item_done;
    assign in_fire         = in_stream.valid && in_stream.ready;

    assign is_eos  = (in_stream.in_byte == TERMINATOR);
    assign is_full = ({1'b0, count_reg} + (COUNT_W + 1)'(1))
                     >= (COUNT_W + 1)'(buffer_length_reg);
    assign hi_code = hi_half_lookup(in_stream.in_byte[6:0]);

    always_comb
    begin
        dec_bytes = hi_code;
        dec_n     = (hi_code[23:16] != 8'h00) ? 2'd3 : 2'd2;
        produce   = 1'b0;
        if (is_eos)
        begin
            dec_bytes = CODE_W'(TERMINATOR);
            dec_n     = 2'd1;
            produce   = 1'b1;
        end
        else if (in_stream.in_byte < ASCII_LIMIT)
        begin
            dec_bytes = CODE_W'(in_stream.in_byte);
            dec_n     = 2'd1;
            produce   = !is_full;
        end
        else
        begin
            produce = !is_full && (hi_code != '0);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            if (is_eos)
            begin
                count_next = '0;
            end
            else if (produce)
            begin
                count_next = count_reg + COUNT_W'(dec_n);
            end
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_idx_next   = item_idx_reg;
        if (in_fire && produce)
        begin
            item_valid_next = 1'b1;
            item_idx_next   = 2'd0;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
            item_idx_next   = 2'd0;
        end
        else if (item_valid_reg && out_load)
        begin
            item_idx_next = item_idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        case (item_idx_reg)
            2'd0:    sel_byte = item_bytes_reg[7:0];
            2'd1:    sel_byte = item_bytes_reg[15:8];
            2'd2:    sel_byte = item_bytes_reg[23:16];
            default: sel_byte = item_bytes_reg[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= BUFFER_LENGTH_RESET;
            count_reg         <= '0;
            item_valid_reg    <= 1'b0;
            item_idx_reg      <= 2'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                buffer_length_reg <= cfg_wr_data;
            end
            count_reg      <= count_next;
            item_valid_reg <= item_valid_next;
            item_idx_reg   <= item_idx_next;
            if (out_load)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && produce)
        begin
            item_bytes_reg <= dec_bytes;
            item_n_reg     <= dec_n;
            item_eos_reg   <= is_eos;
            item_base_reg  <= count_reg;
        end
        if (out_load && item_valid_reg)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= item_last;
            out_eos_reg  <= item_eos_reg;
            out_len_reg  <= item_eos_reg ? item_base_reg
                          : item_base_reg + COUNT_W'(item_idx_reg) + COUNT_W'(1);
        end
    end

    assign out_stream.valid          = out_valid_reg;
    assign out_stream.out_byte       = out_byte_reg;
    assign out_stream.last_of_run    = out_last_reg;
    assign out_stream.end_of_string  = out_eos_reg;
    assign out_stream.written_length = out_len_reg;

    `C2U_ASSERT_SAME(a_idx_in_range, clk, rst_n,
        item_valid_reg, item_idx_reg < item_n_reg)
    `C2U_ASSERT_SAME(a_eos_beat_shape, clk, rst_n,
        out_valid_reg && out_eos_reg, out_last_reg && (out_byte_reg == TERMINATOR))
    `C2U_ASSERT_NEXT(a_full_holds_count, clk, rst_n,
        in_fire && !is_eos && is_full, $stable(count_reg))
    `C2U_ASSERT_NEXT(a_eos_clears_count, clk, rst_n,
        in_fire && is_eos, count_reg == '0)

endmodule
